>>> rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared constants, codes and state type for the voice mixer.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int VOICES       = 8;
    localparam int FILES        = 8;
    localparam int MAX_FRAMES   = 4096;
    localparam int BLOCK_FRAMES = 64;

    localparam int VOICE_W = 3;
    localparam int FILE_W  = 3;
    localparam int OFF_W   = 12;
    localparam int LEN_W   = 13;
    localparam int GAIN_W  = 16;
    localparam int SMP_W   = 16;
    localparam int NCNT_W  = 7;
    localparam int J_W     = $clog2(BLOCK_FRAMES);
    localparam int PC_W    = 4;
    localparam int ADDR_W  = FILE_W + OFF_W;

    // mix sums: up to VOICES products of 16x17 bits
    localparam int ACC_W  = 36;
    localparam int MAG_W  = 35;
    localparam int DIVN_W = 52;
    localparam int QB_W   = 16;

    localparam logic [MAG_W-1:0] UNITY_Q27 = MAG_W'(64'd1 << 27);

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_LENGTH = 3'd1,
        OP_PLAY   = 3'd2,
        OP_LOOP   = 3'd3,
        OP_STOP   = 3'd4,
        OP_PAUSE  = 3'd5,
        OP_RESUME = 3'd6
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_R_INIT,
        ST_V_CHK,
        ST_M_RD,
        ST_M_ML,
        ST_M_MR,
        ST_M_WR,
        ST_V_END,
        ST_P_RD,
        ST_P_CMP,
        ST_O_RD,
        ST_O_CONV,
        ST_O_DIV,
        ST_O_EMIT,
        ST_O_WAIT
    } state_t;

endpackage

>>> rtl/mvm_if.sv
// ----------------------------------------------------------------------------
// mvm_if
// Request and response channels of the voice mixer.
// ----------------------------------------------------------------------------
interface mvm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic        render_req;
    logic [2:0]  file_id;
    logic [11:0] sample_offset;
    logic [15:0] left_in;
    logic [15:0] right_in;
    logic [12:0] file_len;
    logic [15:0] gain;
    logic [2:0]  voice_sel;
    logic [6:0]  frame_count;

    modport source (output valid, opcode, render_req, file_id, sample_offset, left_in,
                    right_in, file_len, gain, voice_sel, frame_count, input ready);
    modport sink   (input valid, opcode, render_req, file_id, sample_offset, left_in,
                    right_in, file_len, gain, voice_sel, frame_count, output ready);
endinterface

interface mvm_rsp_if;
    logic        valid;
    logic        ready;
    logic        is_frame;
    logic [2:0]  voice_out;
    logic        status;
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic        last;

    modport source (output valid, is_frame, voice_out, status, left_out, right_out, last,
                    input ready);
    modport sink   (input valid, is_frame, voice_out, status, left_out, right_out, last,
                    output ready);
endinterface

>>> rtl/multi_voice_sample_mixer_top.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_top
// Stereo sample-playback mixer: sample store, eight voices, block render
// with peak normalization through a shared multiplier and serial divider.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  req     | in  | command or render request
//  rsp     | out | acknowledge, or one mixed frame per response
//
//  Commands: accept, an execute state, then the response waits until it is
//  taken. Render: voice checks, then per mixed frame of each active voice a
//  read, a left and a right multiply and a write; then a peak search over
//  the block. Then each frame is read and converted, through a 16-step
//  divider per channel when the block is normalized, and waits for its
//  response handshake. The divider sets the worst case.
//  Reset clears voices, lengths and counts at once; the store is not cleared.
//  One request at a time; req.ready is low until the last response is taken.
module multi_voice_sample_mixer_top (
    input  logic clk,
    input  logic rst_n,
    mvm_req_if.sink   req,
    mvm_rsp_if.source rsp
);
    import mvm_pkg::*;

    state_t state_reg, state_next;

    // captured request
    logic [2:0]        op_reg;
    logic [FILE_W-1:0] file_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [31:0]       smp_in_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [GAIN_W-1:0] gain_in_reg;
    logic [VOICE_W-1:0] vsel_reg;
    logic [NCNT_W-1:0] n_reg;

    // voice state
    logic [LEN_W-1:0]   flen_reg  [FILES];
    logic [FILE_W-1:0]  vfile_reg [VOICES];
    logic [LEN_W-1:0]   vpos_reg  [VOICES];
    logic [LEN_W-1:0]   vleft_reg [VOICES];
    logic [GAIN_W-1:0]  vgain_reg [VOICES];
    logic               vloop_reg [VOICES];
    logic               vplay_reg [VOICES];
    logic               vused_reg [VOICES];
    logic [PC_W-1:0]    pcount_reg;

    // render datapath
    logic [VOICE_W-1:0] v_reg;
    logic [J_W-1:0]     j_reg;
    logic [NCNT_W-1:0]  end_reg;
    logic signed [31:0] mul_reg;
    logic signed [ACC_W-1:0] accl_reg;
    logic [MAG_W-1:0]   peak_reg;
    logic [BLOCK_FRAMES-1:0] mvld_reg;
    logic               ch_reg;
    logic               neg_reg;
    logic [ACC_W-1:0]   rem_reg;
    logic [QB_W-1:0]    nlow_reg;
    logic [QB_W-1:0]    q_reg;
    logic [3:0]         dcnt_reg;
    logic [SMP_W-1:0]   resl_reg;
    logic [SMP_W-1:0]   resr_reg;

    // response register
    logic               out_valid_reg;
    logic               o_frame_reg;
    logic [VOICE_W-1:0] o_voice_reg;
    logic               o_status_reg;
    logic [SMP_W-1:0]   o_left_reg;
    logic [SMP_W-1:0]   o_right_reg;
    logic               o_last_reg;

    // memories
    logic [31:0]        store_mem [FILES * MAX_FRAMES];
    logic [31:0]        store_q;
    logic               zero_q;
    logic [2*ACC_W-1:0] mix_mem [BLOCK_FRAMES];
    logic [2*ACC_W-1:0] mix_q;
    logic               vld_q;

    // ------------------------------------------------------------------
    // combinational helpers
    logic               free_found;
    logic [VOICE_W-1:0] free_idx;
    logic               file_bad, off_bad, vsel_bad;
    logic [LEN_W-1:0]   p_full;
    logic [ADDR_W-1:0]  rd_addr;
    logic               act;
    logic [NCNT_W-1:0]  end_c;
    logic               j_done, p_done;
    logic [LEN_W-1:0]   npos, nleft;
    logic [NCNT_W-1:0]  n_clamp;
    logic signed [SMP_W-1:0]  smp_sel;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [31:0] prod;
    logic signed [ACC_W-1:0] mixl, mixr, csum;
    logic [MAG_W-1:0]   magl, magr, cmag;
    logic               cneg, norm;
    logic [ACC_W-1:0]   rnd;
    logic [23:0]        rq;
    logic [QB_W:0]      sat;
    logic [SMP_W-1:0]   dir_val;
    logic [DIVN_W-1:0]  div_n;
    logic [ACC_W:0]     dt, dd;
    logic               dge;
    logic [QB_W-1:0]    q_new;
    logic [QB_W:0]      qs;
    logic [SMP_W-1:0]   div_val;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!vused_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VOICE_W'(i);
            end
        end
    end

    assign file_bad = 32'(file_reg) >= FILES;
    assign off_bad  = 32'(off_reg) >= MAX_FRAMES;
    assign vsel_bad = 32'(vsel_reg) >= VOICES;

    assign n_clamp = (req.frame_count == '0) ? NCNT_W'(1) :
                     (32'(req.frame_count) > BLOCK_FRAMES) ? NCNT_W'(BLOCK_FRAMES) :
                     req.frame_count;

    // voice walk
    assign p_full  = vpos_reg[v_reg] + LEN_W'(j_reg);
    assign rd_addr = {vfile_reg[v_reg], p_full[OFF_W-1:0]};
    assign act     = vplay_reg[v_reg] && vused_reg[v_reg];
    assign end_c   = (vleft_reg[v_reg] < LEN_W'(n_reg)) ? NCNT_W'(vleft_reg[v_reg]) : n_reg;
    assign j_done  = (NCNT_W'(j_reg) + NCNT_W'(1)) == end_reg;
    assign p_done  = (NCNT_W'(j_reg) + NCNT_W'(1)) == n_reg;
    assign npos    = vpos_reg[v_reg] + LEN_W'(end_reg);
    assign nleft   = vleft_reg[v_reg] - LEN_W'(end_reg);

    // shared multiplier: left in M_ML, right in M_MR
    assign smp_sel = zero_q ? '0 :
                     (state_reg == ST_M_ML) ? $signed(store_q[31:16]) : $signed(store_q[15:0]);
    assign gain_s  = $signed({1'b0, vgain_reg[v_reg]});
    assign prod    = 32'(smp_sel) * 32'(gain_s);

    // mix buffer entries, zero when untouched this block
    assign mixl = vld_q ? $signed(mix_q[2*ACC_W-1:ACC_W]) : '0;
    assign mixr = vld_q ? $signed(mix_q[ACC_W-1:0]) : '0;
    assign magl = mixl[ACC_W-1] ? MAG_W'(-mixl) : MAG_W'(mixl);
    assign magr = mixr[ACC_W-1] ? MAG_W'(-mixr) : MAG_W'(mixr);
    assign norm = peak_reg > UNITY_Q27;

    // Q27 to Q15 conversion, direct path
    assign csum    = ch_reg ? mixr : mixl;
    assign cneg    = csum[ACC_W-1];
    assign cmag    = ch_reg ? magr : magl;
    assign rnd     = ACC_W'(cmag) + ACC_W'(2048);
    assign rq      = rnd[ACC_W-1:12];
    assign sat     = cneg ? ((rq > 24'd32768) ? 17'd32768 : rq[QB_W:0]) :
                            ((rq > 24'd32767) ? 17'd32767 : rq[QB_W:0]);
    assign dir_val = cneg ? SMP_W'(-sat) : SMP_W'(sat);

    // normalizing path: q = (2*mag*32767 + peak) / (2*peak)
    assign div_n   = DIVN_W'({cmag, 16'h0}) - DIVN_W'({cmag, 1'b0}) + DIVN_W'(peak_reg);
    assign dt      = {rem_reg, nlow_reg[QB_W-1]};
    assign dd      = {1'b0, peak_reg, 1'b0};
    assign dge     = dt >= dd;
    assign q_new   = {q_reg[QB_W-2:0], dge};
    assign qs      = {1'b0, q_new};
    assign div_val = neg_reg ? SMP_W'(-qs) : SMP_W'(qs);

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (req.valid) state_next = req.render_req ? ST_R_INIT : ST_CMD;
            ST_CMD:    state_next = ST_O_WAIT;
            ST_R_INIT: state_next = ST_V_CHK;
            ST_V_CHK:
            begin
                if (act && end_c != '0)
                    state_next = ST_M_RD;
                else if (act)
                    state_next = ST_V_END;
                else if (32'(v_reg) == VOICES - 1)
                    state_next = ST_P_RD;
            end
            ST_M_RD:   state_next = ST_M_ML;
            ST_M_ML:   state_next = ST_M_MR;
            ST_M_MR:   state_next = ST_M_WR;
            ST_M_WR:   state_next = j_done ? ST_V_END : ST_M_RD;
            ST_V_END:  state_next = (32'(v_reg) == VOICES - 1) ? ST_P_RD : ST_V_CHK;
            ST_P_RD:   state_next = ST_P_CMP;
            ST_P_CMP:  state_next = p_done ? ST_O_RD : ST_P_RD;
            ST_O_RD:   state_next = ST_O_CONV;
            ST_O_CONV:
            begin
                if (norm)
                    state_next = ST_O_DIV;
                else if (ch_reg)
                    state_next = ST_O_EMIT;
            end
            ST_O_DIV:
            begin
                if (dcnt_reg == 4'd15)
                    state_next = ch_reg ? ST_O_EMIT : ST_O_CONV;
            end
            ST_O_EMIT: state_next = ST_O_WAIT;
            ST_O_WAIT:
            begin
                if (rsp.ready)
                    state_next = (o_frame_reg && !o_last_reg) ? ST_O_RD : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // port outputs
    always_comb
    begin
        req.ready     = (state_reg == ST_IDLE);
        rsp.valid     = out_valid_reg;
        rsp.is_frame  = o_frame_reg;
        rsp.voice_out = o_voice_reg;
        rsp.status    = o_status_reg;
        rsp.left_out  = o_left_reg;
        rsp.right_out = o_right_reg;
        rsp.last      = o_last_reg;
    end

    // ------------------------------------------------------------------
    // control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pcount_reg    <= '0;
            mvld_reg      <= '0;
            for (int i = 0; i < FILES; i++)
                flen_reg[i] <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                vfile_reg[i] <= '0;
                vpos_reg[i]  <= '0;
                vleft_reg[i] <= '0;
                vgain_reg[i] <= '0;
                vloop_reg[i] <= 1'b0;
                vplay_reg[i] <= 1'b0;
                vused_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_CMD:
                begin
                    out_valid_reg <= 1'b1;
                    case (op_reg)
                        OP_LENGTH:
                            if (!file_bad)
                                flen_reg[file_reg] <= (32'(len_reg) > MAX_FRAMES) ?
                                                      LEN_W'(MAX_FRAMES) : len_reg;
                        OP_PLAY, OP_LOOP:
                            if (!file_bad && free_found)
                            begin
                                vfile_reg[free_idx] <= file_reg;
                                vpos_reg[free_idx]  <= '0;
                                vleft_reg[free_idx] <= flen_reg[file_reg];
                                vgain_reg[free_idx] <= gain_in_reg;
                                vused_reg[free_idx] <= 1'b1;
                                vplay_reg[free_idx] <= 1'b1;
                                vloop_reg[free_idx] <= (op_reg == OP_LOOP);
                                pcount_reg          <= pcount_reg + PC_W'(1);
                            end
                        OP_STOP, OP_PAUSE:
                            if (!vsel_bad)
                            begin
                                if (vplay_reg[vsel_reg] && pcount_reg != '0)
                                    pcount_reg <= pcount_reg - PC_W'(1);
                                vplay_reg[vsel_reg] <= 1'b0;
                                if (op_reg == OP_STOP)
                                begin
                                    vused_reg[vsel_reg] <= 1'b0;
                                    vloop_reg[vsel_reg] <= 1'b0;
                                end
                            end
                        OP_RESUME:
                            if (!vsel_bad && vused_reg[vsel_reg] && !vplay_reg[vsel_reg])
                            begin
                                vplay_reg[vsel_reg] <= 1'b1;
                                pcount_reg          <= pcount_reg + PC_W'(1);
                            end
                        default: ;
                    endcase
                end
                ST_R_INIT: mvld_reg <= '0;
                ST_M_WR:   mvld_reg[j_reg] <= 1'b1;
                ST_V_END:
                begin
                    if (nleft == '0)
                    begin
                        if (vloop_reg[v_reg])
                        begin
                            vpos_reg[v_reg]  <= '0;
                            vleft_reg[v_reg] <= flen_reg[vfile_reg[v_reg]];
                        end
                        else
                        begin
                            vpos_reg[v_reg]  <= npos;
                            vleft_reg[v_reg] <= nleft;
                            vplay_reg[v_reg] <= 1'b0;
                            vused_reg[v_reg] <= 1'b0;
                            vloop_reg[v_reg] <= 1'b0;
                            if (pcount_reg != '0)
                                pcount_reg <= pcount_reg - PC_W'(1);
                        end
                    end
                    else
                    begin
                        vpos_reg[v_reg]  <= npos;
                        vleft_reg[v_reg] <= nleft;
                    end
                end
                ST_O_EMIT: out_valid_reg <= 1'b1;
                ST_O_WAIT: if (rsp.ready) out_valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg      <= req.opcode;
                file_reg    <= req.file_id;
                off_reg     <= req.sample_offset;
                smp_in_reg  <= {req.left_in, req.right_in};
                len_reg     <= req.file_len;
                gain_in_reg <= req.gain;
                vsel_reg    <= req.voice_sel;
                n_reg       <= n_clamp;
            end
            ST_CMD:
            begin
                o_frame_reg <= 1'b0;
                o_left_reg  <= '0;
                o_right_reg <= '0;
                o_last_reg  <= 1'b1;
                o_voice_reg <= '0;
                case (op_reg)
                    OP_WRITE:  o_status_reg <= file_bad || off_bad;
                    OP_LENGTH: o_status_reg <= file_bad;
                    OP_PLAY, OP_LOOP:
                    begin
                        o_status_reg <= file_bad || !free_found;
                        if (!file_bad && free_found)
                            o_voice_reg <= free_idx;
                    end
                    OP_STOP, OP_PAUSE, OP_RESUME: o_status_reg <= vsel_bad;
                    default:   o_status_reg <= 1'b1;
                endcase
            end
            ST_R_INIT:
            begin
                v_reg    <= '0;
                peak_reg <= '0;
            end
            ST_V_CHK:
            begin
                j_reg   <= '0;
                end_reg <= end_c;
                if (!act && 32'(v_reg) != VOICES - 1)
                    v_reg <= v_reg + VOICE_W'(1);
            end
            ST_M_ML: mul_reg <= prod;
            ST_M_MR:
            begin
                accl_reg <= mixl + ACC_W'(mul_reg);
                mul_reg  <= prod;
            end
            ST_M_WR: if (!j_done) j_reg <= j_reg + J_W'(1);
            ST_V_END:
            begin
                j_reg <= '0;
                if (32'(v_reg) != VOICES - 1)
                    v_reg <= v_reg + VOICE_W'(1);
            end
            ST_P_CMP:
            begin
                if (magl > peak_reg && magl >= magr)
                    peak_reg <= magl;
                else if (magr > peak_reg)
                    peak_reg <= magr;
                j_reg <= p_done ? '0 : j_reg + J_W'(1);
            end
            ST_O_RD: ch_reg <= 1'b0;
            ST_O_CONV:
            begin
                if (norm)
                begin
                    rem_reg  <= div_n[DIVN_W-1:QB_W];
                    nlow_reg <= div_n[QB_W-1:0];
                    q_reg    <= '0;
                    dcnt_reg <= '0;
                    neg_reg  <= cneg;
                end
                else if (!ch_reg)
                begin
                    resl_reg <= dir_val;
                    ch_reg   <= 1'b1;
                end
                else
                    resr_reg <= dir_val;
            end
            ST_O_DIV:
            begin
                rem_reg  <= dge ? ACC_W'(dt - dd) : dt[ACC_W-1:0];
                nlow_reg <= {nlow_reg[QB_W-2:0], 1'b0};
                q_reg    <= q_new;
                dcnt_reg <= dcnt_reg + 4'd1;
                if (dcnt_reg == 4'd15)
                begin
                    if (!ch_reg)
                    begin
                        resl_reg <= div_val;
                        ch_reg   <= 1'b1;
                    end
                    else
                        resr_reg <= div_val;
                end
            end
            ST_O_EMIT:
            begin
                o_frame_reg  <= 1'b1;
                o_voice_reg  <= '0;
                o_status_reg <= 1'b0;
                o_left_reg   <= resl_reg;
                o_right_reg  <= resr_reg;
                o_last_reg   <= p_done;
            end
            ST_O_WAIT:
                if (rsp.ready && o_frame_reg && !o_last_reg)
                    j_reg <= j_reg + J_W'(1);
            default: ;
        endcase
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMD && op_reg == OP_WRITE && !file_bad && !off_bad)
            store_mem[{file_reg, off_reg}] <= smp_in_reg;
        store_q <= store_mem[rd_addr];
        zero_q  <= p_full[LEN_W-1];
    end

    // mix buffer
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_M_WR)
            mix_mem[j_reg] <= {accl_reg, mixr + ACC_W'(mul_reg)};
        mix_q <= mix_mem[j_reg];
        vld_q <= mvld_reg[j_reg];
    end

`ifndef NO_ASSERTIONS
    a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pcount_reg) <= VOICES)
        else $error("playing count above voice count");
    a_valid_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_O_WAIT)
        else $error("response shown outside wait state");
    a_div_norm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_O_DIV |-> norm)
        else $error("divider running on a block below full scale");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !out_valid_reg)
        else $error("request taken while response pending");
`endif

endmodule
